@@ hdl/tss_pkg.sv @@
// shared types, codes and helpers of the tdma slot transmit scheduler
package tss_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int ENTRY_W     = 32;
    localparam int DVD_W       = 33;
    localparam int REM_STEPS   = DVD_W;
    localparam int CNT_W       = $clog2(REM_STEPS + 1);

    localparam logic [31:0] PERIOD_RST = 32'd32768;
    localparam logic [31:0] SLOT_RST   = 32'd10922;
    localparam logic [31:0] GUARD_RST  = 32'd2730;
    localparam logic [7:0]  NODE_RST   = 8'd0;

    localparam logic [1:0] MODE_ENQ   = 2'd0;
    localparam logic [1:0] MODE_TIMER = 2'd1;
    localparam logic [1:0] MODE_DONE  = 2'd2;

    localparam logic [1:0] KIND_ACCEPT = 2'd0;
    localparam logic [1:0] KIND_DROP   = 2'd1;
    localparam logic [1:0] KIND_SEND   = 2'd2;
    localparam logic [1:0] KIND_WAKE   = 2'd3;

    localparam logic [1:0] CFG_PERIOD = 2'd0;
    localparam logic [1:0] CFG_SLOT   = 2'd1;
    localparam logic [1:0] CFG_GUARD  = 2'd2;
    localparam logic [1:0] CFG_NODE   = 2'd3;

    typedef logic [PTR_W-1:0] ptr_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENQ_WAKE,
        ST_DIV1,
        ST_BASE,
        ST_CHECK,
        ST_DIV2,
        ST_LATE,
        ST_READ,
        ST_ISSUE
    } state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] handle;
        logic [15:0] number;
        logic [31:0] wake;
        logic [15:0] total;
        logic        last;
    } result_t;

    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        if (p == ptr_t'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + ptr_t'(1);
        end
        return r;
    endfunction

    function automatic result_t make_result(
        input logic [1:0]  kind,
        input logic [15:0] handle,
        input logic [15:0] number,
        input logic [31:0] wake,
        input logic [15:0] total,
        input logic        last
    );
        result_t r;
        r.kind   = kind;
        r.handle = handle;
        r.number = number;
        r.wake   = wake;
        r.total  = total;
        r.last   = last;
        return r;
    endfunction

endpackage

@@ hdl/tdma_slot_transmit_scheduler.sv @@
// top level of the tdma slot transmit scheduler: control, registers and ring
//
// Commands enter on start/mode/now/packet_handle/send_ok and are taken when
// start is high and busy is low. Results leave one per cycle on strobe with
// kind, out_handle, packet_number, wake_time, sent_total and last; the
// receiver always takes them. A command gives zero, one or two results.
// Results per command, in order:
//   enqueue: an accept or drop word; the first accepted enqueue adds the wake word next cycle
//   send done: a wake word, or the next handle issued through the read and issue states
//   timer fire: a remainder of now by the period, then the base and check steps,
//   then a wake or an issued handle; skipping ahead takes a second remainder
// Each remainder by the period runs through the serial remainder unit; busy
// stays high until the last result is loaded. Handles and numbers live in
// a ring ram with a registered read. Configuration writes land at once; the
// user makes them only while busy is low, the block does not enforce it.
// Reset clears pointers, counters, flags and config to defaults; the ring
// needs no clearing pass, entries are always written before they are read.
module tdma_slot_transmit_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [31:0] now,
    input  logic [15:0] packet_handle,
    input  logic        send_ok,
    output logic        strobe,
    output logic [1:0]  kind,
    output logic [15:0] out_handle,
    output logic [15:0] packet_number,
    output logic [31:0] wake_time,
    output logic [15:0] sent_total,
    output logic        last
);
    import tss_pkg::*;

    logic [31:0] period_reg;
    logic [31:0] slot_reg;
    logic [31:0] guard_reg;
    logic [7:0]  node_reg;

    state_t      state_reg, state_next;
    ptr_t        wp_reg, wp_next;
    ptr_t        rp_reg, rp_next;
    logic [15:0] pc_reg, pc_next;
    logic [15:0] sc_reg, sc_next;
    logic [31:0] css_reg, css_next;
    logic        ts_reg, ts_next;
    logic        so_reg, so_next;
    logic [31:0] now_reg, now_next;
    logic [39:0] prod_reg, prod_next;
    logic [40:0] start_reg, start_next;
    logic [31:0] gap_reg, gap_next;
    logic [31:0] adj_reg, adj_next;
    result_t     res_reg, res_next;
    logic        strobe_reg, strobe_next;

    logic        accept;
    logic [31:0] per_eff;
    ptr_t        wp_inc;
    ptr_t        rp_inc;
    logic        ring_full;
    logic        ring_filled;
    logic [15:0] pc_inc;
    logic [15:0] sc_upd;
    logic [32:0] send_need;
    logic [32:0] css_end;
    logic        issue_more;
    logic [41:0] slot_end;
    logic [32:0] need_chk;
    logic        early;
    logic        late;
    logic [32:0] gap;

    logic              ram_we;
    logic [ENTRY_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ENTRY_W-1:0] ram_rdata;

    logic              rem_start;
    logic [DVD_W-1:0]  rem_dividend;
    logic              rem_done;
    logic [31:0]       rem_val;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RST;
            slot_reg   <= SLOT_RST;
            guard_reg  <= GUARD_RST;
            node_reg   <= NODE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PERIOD: period_reg <= cfg_data;
                CFG_SLOT:   slot_reg   <= cfg_data;
                CFG_GUARD:  guard_reg  <= cfg_data;
                CFG_NODE:   node_reg   <= cfg_data[7:0];
                default:    ;
            endcase
        end
    end

    assign busy        = state_reg != ST_IDLE;
    assign accept      = start && !busy;
    assign per_eff     = (period_reg == 32'd0) ? 32'd1 : period_reg;
    assign wp_inc      = ptr_inc(wp_reg);
    assign rp_inc      = ptr_inc(rp_reg);
    assign ring_full   = wp_inc == rp_reg;
    assign ring_filled = rp_reg != wp_reg;
    assign pc_inc      = pc_reg + 16'd1;
    assign sc_upd      = sc_reg + {15'd0, send_ok};
    assign send_need   = {1'b0, now} + {1'b0, guard_reg};
    assign css_end     = {1'b0, css_reg} + {1'b0, slot_reg};
    assign issue_more  = (rp_inc != wp_reg) && (send_need <= css_end);
    assign slot_end    = {1'b0, start_reg} + {10'd0, slot_reg};
    assign need_chk    = {1'b0, now_reg} + {1'b0, guard_reg};
    assign early       = {9'd0, now_reg} < start_reg;
    assign late        = {9'd0, need_chk} > slot_end;
    assign gap         = need_chk - slot_end[32:0];

    // ring ram: handle in the upper half, number in the lower half
    assign ram_we    = accept && (mode == MODE_ENQ) && !ring_full;
    assign ram_wdata = {packet_handle, pc_inc};
    assign ram_re    = state_reg == ST_READ;

    tss_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rp_reg),
        .rdata (ram_rdata)
    );

    assign rem_start = (accept && (mode == MODE_TIMER) && !so_reg)
                       || ((state_reg == ST_CHECK) && late);
    assign rem_dividend = (state_reg == ST_CHECK) ? gap : {1'b0, now};

    tss_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (rem_dividend),
        .divisor  (per_eff),
        .done     (rem_done),
        .rem      (rem_val)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_ENQ:
                        begin
                            if (!ring_full && !ts_reg)
                            begin
                                state_next = ST_ENQ_WAKE;
                            end
                        end
                        MODE_TIMER:
                        begin
                            if (!so_reg)
                            begin
                                state_next = ST_DIV1;
                            end
                        end
                        MODE_DONE:
                        begin
                            if (so_reg && issue_more)
                            begin
                                state_next = ST_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_ENQ_WAKE: state_next = ST_IDLE;
            ST_DIV1:
            begin
                if (rem_done)
                begin
                    state_next = ST_BASE;
                end
            end
            ST_BASE: state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (late)
                begin
                    state_next = ST_DIV2;
                end
                else if (!early && ring_filled)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV2:
            begin
                if (rem_done)
                begin
                    state_next = ST_LATE;
                end
            end
            ST_LATE:  state_next = ST_IDLE;
            ST_READ:  state_next = ST_ISSUE;
            ST_ISSUE: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and result words
    always_comb
    begin
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        pc_next     = pc_reg;
        sc_next     = sc_reg;
        css_next    = css_reg;
        ts_next     = ts_reg;
        so_next     = so_reg;
        now_next    = now_reg;
        prod_next   = prod_reg;
        start_next  = start_reg;
        gap_next    = gap_reg;
        adj_next    = adj_reg;
        res_next    = res_reg;
        strobe_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_ENQ:
                        begin
                            pc_next     = pc_inc;
                            now_next    = now;
                            strobe_next = 1'b1;
                            if (ring_full)
                            begin
                                res_next = make_result(KIND_DROP, packet_handle, pc_inc,
                                                       32'd0, sc_reg, 1'b1);
                            end
                            else
                            begin
                                wp_next  = wp_inc;
                                ts_next  = 1'b1;
                                res_next = make_result(KIND_ACCEPT, packet_handle, pc_inc,
                                                       32'd0, sc_reg, ts_reg);
                            end
                        end
                        MODE_TIMER:
                        begin
                            if (!so_reg)
                            begin
                                now_next  = now;
                                prod_next = 40'(node_reg) * 40'(slot_reg);
                            end
                        end
                        MODE_DONE:
                        begin
                            if (so_reg)
                            begin
                                so_next = 1'b0;
                                sc_next = sc_upd;
                                rp_next = rp_inc;
                                if (!issue_more)
                                begin
                                    strobe_next = 1'b1;
                                    res_next    = make_result(KIND_WAKE, 16'd0, 16'd0,
                                                              css_reg + per_eff, sc_upd, 1'b1);
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_ENQ_WAKE:
            begin
                strobe_next = 1'b1;
                res_next    = make_result(KIND_WAKE, 16'd0, 16'd0, now_reg + per_eff,
                                          sc_reg, 1'b1);
            end
            ST_BASE:
            begin
                start_next = {9'd0, now_reg - rem_val} + {1'b0, prod_reg};
            end
            ST_CHECK:
            begin
                if (late)
                begin
                    gap_next = gap[31:0];
                end
                else if (early)
                begin
                    strobe_next = 1'b1;
                    res_next    = make_result(KIND_WAKE, 16'd0, 16'd0, start_reg[31:0],
                                              sc_reg, 1'b1);
                end
                else
                begin
                    css_next = start_reg[31:0];
                    if (!ring_filled)
                    begin
                        strobe_next = 1'b1;
                        res_next    = make_result(KIND_WAKE, 16'd0, 16'd0,
                                                  start_reg[31:0] + per_eff, sc_reg, 1'b1);
                    end
                end
            end
            ST_DIV2:
            begin
                if (rem_done)
                begin
                    // round the distance up to whole periods
                    adj_next = (rem_val == 32'd0) ? 32'd0 : per_eff - rem_val;
                end
            end
            ST_LATE:
            begin
                strobe_next = 1'b1;
                res_next    = make_result(KIND_WAKE, 16'd0, 16'd0,
                                          start_reg[31:0] + gap_reg + adj_reg, sc_reg, 1'b1);
            end
            ST_ISSUE:
            begin
                so_next     = 1'b1;
                strobe_next = 1'b1;
                res_next    = make_result(KIND_SEND, ram_rdata[31:16], ram_rdata[15:0],
                                          32'd0, sc_reg, 1'b1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wp_reg     <= '0;
            rp_reg     <= '0;
            pc_reg     <= '0;
            sc_reg     <= '0;
            css_reg    <= '0;
            ts_reg     <= 1'b0;
            so_reg     <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wp_reg     <= wp_next;
            rp_reg     <= rp_next;
            pc_reg     <= pc_next;
            sc_reg     <= sc_next;
            css_reg    <= css_next;
            ts_reg     <= ts_next;
            so_reg     <= so_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg   <= now_next;
        prod_reg  <= prod_next;
        start_reg <= start_next;
        gap_reg   <= gap_next;
        adj_reg   <= adj_next;
        res_reg   <= res_next;
    end

    assign strobe        = strobe_reg;
    assign kind          = res_reg.kind;
    assign out_handle    = res_reg.handle;
    assign packet_number = res_reg.number;
    assign wake_time     = res_reg.wake;
    assign sent_total    = res_reg.total;
    assign last          = res_reg.last;

endmodule

@@ hdl/tss_ram.sv @@
// generic single-port-write ram with registered read
module tss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/tss_rem.sv @@
// bit-serial remainder unit, one dividend bit per cycle
module tss_rem (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [tss_pkg::DVD_W-1:0] dividend,
    input  logic [31:0]               divisor,
    output logic                      done,
    output logic [31:0]               rem
);
    import tss_pkg::*;

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [31:0]      div_reg;
    logic [31:0]      rem_reg;
    logic [32:0]      trial;
    logic [32:0]      diff;
    logic [31:0]      rem_next;
    logic             last_step;

    assign last_step = cnt_reg == CNT_W'(REM_STEPS - 1);

    always_comb
    begin
        trial = {rem_reg, dvd_reg[DVD_W-1]};
        diff  = trial - {1'b0, div_reg};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = diff[31:0];
        end
        else
        begin
            rem_next = trial[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

@@ hdl/tss_checker.sv @@
// port-level checks of the tdma slot transmit scheduler and their binding
module tss_assertions (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        strobe,
    input logic [1:0]  kind,
    input logic        last
);
    import tss_pkg::*;

    // busy is only entered by taking a command
    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a command");

    // a non-final word is an accept followed at once by the final wake word
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> kind == KIND_ACCEPT ##1 (strobe && last && kind == KIND_WAKE))
        else $error("two-word answer out of shape");

    // a drop answers a command taken while idle and ends it
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && kind == KIND_DROP |-> last && !$past(busy))
        else $error("drop word malformed");

    // a transmit word comes out of a busy phase and ends the answer
    a_send: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && kind == KIND_SEND |-> last && $past(busy))
        else $error("transmit word malformed");

endmodule

bind tdma_slot_transmit_scheduler tss_assertions u_tss_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .kind   (kind),
    .last   (last)
);
